/* rtl/tals_pkg.sv */
// Package for the two-axis line step generator: action and status codes,
// register indexes, widths and the structs between sequencer and divide/root unit.
// Depends on nothing.
package tals_pkg;
   localparam int ACT_W = 3;
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_MOVE  = 3'd1;
   localparam logic [2:0] ACT_HOLD  = 3'd2;
   localparam logic [2:0] ACT_PAUSE = 3'd3;
   localparam logic [2:0] ACT_START = 3'd4;
   localparam logic [2:0] ACT_RESET = 3'd5;

   localparam logic [3:0] ST_NONE      = 4'd0;
   localparam logic [3:0] ST_ACCEPTED  = 4'd1;
   localparam logic [3:0] ST_REFUSED   = 4'd2;
   localparam logic [3:0] ST_X_LIMIT   = 4'd3;
   localparam logic [3:0] ST_Y_LIMIT   = 4'd4;
   localparam logic [3:0] ST_NO_MOVE   = 4'd5;
   localparam logic [3:0] ST_STEPPING  = 4'd6;
   localparam logic [3:0] ST_DONE      = 4'd7;
   localparam logic [3:0] ST_INTERRUPT = 4'd8;
   localparam logic [3:0] ST_LIMIT     = 4'd9;
   localparam logic [3:0] ST_NO_RESUME = 4'd10;

   localparam logic [1:0] REG_X_SPM  = 2'd0;
   localparam logic [1:0] REG_Y_SPM  = 2'd1;
   localparam logic [1:0] REG_FEED   = 2'd2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam logic [19:0] SPM_RESET  = 20'd20480;
   localparam logic [15:0] FEED_RESET = 16'd1000;

   localparam int FRAC = 20;
   localparam logic [63:0] NOMOVE_Q20 = 64'd1049;
   localparam logic [63:0] US_PER_MIN = 64'd60000000;

   // Operation for the shared divide / root unit.
   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [63:0] num;
      logic [63:0] den;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;
endpackage

/* rtl/tals_if.sv */
// Valid/ready channel interface for items of the step generator.
// Parameterized by payload type; no package dependency.
interface tals_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tals_alu.sv */
// Shared iterative unit: 64-bit restoring divide (one quotient bit a cycle)
// or integer square root (one result bit a cycle). Uses tals_pkg.
module tals_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  tals_pkg::alu_cmd_type cmd,
   output tals_pkg::alu_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;     // dividend / radicand remaining
   logic [63:0] d_ff, d_in;     // divisor
   logic [63:0] q_ff, q_in;     // quotient / root
   logic [63:0] r_ff, r_in;     // remainder
   logic        done_ff, done_in;
   logic [64:0] rs;
   logic [65:0] trial;

   always_comb begin
      busy_in = busy_ff; sqrt_in = sqrt_ff; cnt_in = cnt_ff;
      a_in = a_ff; d_in = d_ff; q_in = q_ff; r_in = r_ff; done_in = 1'b0;
      rs = '0; trial = '0;
      if (cmd.start) begin
         busy_in = 1'b1; sqrt_in = cmd.is_sqrt;
         cnt_in = cmd.is_sqrt ? 7'd32 : 7'd64;
         a_in = cmd.num; d_in = cmd.den; q_in = '0; r_in = '0;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            // Digit-by-digit root: bring down two bits.
            trial = {2'b00, r_ff} << 2 | {64'd0, a_ff[63:62]};
            if (trial >= {q_ff, 2'b01}) begin
               r_in = 64'(trial - {q_ff, 2'b01});
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               r_in = trial[63:0];
               q_in = {q_ff[62:0], 1'b0};
            end
            a_in = {a_ff[61:0], 2'b00};
         end else begin
            rs = {r_ff, a_ff[63]};
            if (rs >= {1'b0, d_ff}) begin
               r_in = 64'(rs - {1'b0, d_ff});
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               r_in = rs[63:0];
               q_in = {q_ff[62:0], 1'b0};
            end
            a_in = {a_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      sqrt_ff <= sqrt_in; a_ff <= a_in; d_ff <= d_in; q_ff <= q_in; r_ff <= r_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = q_ff;
endmodule

/* rtl/two_axis_line_step_generator.sv */
// Top level of the two-axis line step generator: channel handling, sequencer,
// motion state and Bresenham step. Depends on tals_pkg and tals_alu.
//
// Usage: each request item carries one event (tick, move, feed hold, pause,
// cycle start or reset) with the sampled limit switch levels, and every request
// yields exactly one response item with the step pulses, directions, positions,
// the moving flag and a status code. Steppers are driven by the step pulses.
//
// Sequencing: ticks, hold, pause, cycle start, reset and refused moves pass
// through the execute state and the output state to a valid response. An
// accepted move runs through the shared divide/root unit: two ratio divides,
// two mm-per-step divides, one root, and one feed divide, each issued when
// the one before it is done; a move found too short after the root skips the
// feed divide. The request channel is not ready while an item is in work or
// while the response register is still full; a stalled receiver simply holds
// the response and the block waits. Synchronous reset clears all motion
// state, positions and flags and loads the register defaults.
module two_axis_line_step_generator #(
   parameter int POS_BITS        = 32,
   parameter int MIN_INTERVAL_US = 1000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [tals_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tals_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_action,
   input  logic signed [31:0]              req_goal_x,
   input  logic signed [31:0]              req_goal_y,
   input  logic [15:0]                     req_feed,
   input  logic                            req_limit_x,
   input  logic                            req_limit_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_step_x,
   output logic                            rsp_dir_x,
   output logic                            rsp_step_y,
   output logic                            rsp_dir_y,
   output logic signed [31:0]              rsp_at_x,
   output logic signed [31:0]              rsp_at_y,
   output logic                            rsp_moving,
   output logic [3:0]                      rsp_status
);
   localparam int PB = POS_BITS;

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_RX = 4'd2, S_RY = 4'd3,
                          S_MX = 4'd4, S_MY = 4'd5, S_SQ = 4'd6, S_IV = 4'd7,
                          S_FIN = 4'd8, S_OUT = 4'd9;

   logic [3:0] st_ff, st_in;
   logic [19:0] xspm_ff, yspm_ff;
   logic [15:0] dfeed_ff;

   logic [PB-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [PB-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [PB-1:0] steps_ff, steps_in;
   logic signed [PB+1:0] err_ff, err_in;
   logic [31:0] intv_ff, intv_in, cd_ff, cd_in;
   logic [1:0] dirs_ff, dirs_in;
   logic hold_ff, hold_in, pause_ff, pause_in, busy_ff, busy_in;

   // Captured item.
   logic [2:0] act_ff; logic [31:0] gx_ff, gy_ff; logic [15:0] feed_ff;
   logic lx_ff, ly_ff;

   // Move working registers.
   logic [PB-1:0] ax_ff, ax_in, ay_ff, ay_in, tot_ff, tot_in;
   logic [1:0] mdir_ff, mdir_in;
   logic [63:0] mx_ff, mx_in, my_ff, my_in, q_ff, q_in;
   logic [63:0] acc_ff, acc_in; // holds the X ratio until its mm-per-step divide

   // Response register.
   logic ov_ff, ov_in, osx_ff, osx_in, osy_ff, osy_in;
   logic [3:0] ost_ff, ost_in;

   tals_pkg::alu_cmd_type cmd;
   tals_pkg::alu_rsp_type ar;
   tals_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(ar));

   assign req_ready = (st_ff == S_IDLE) && !ov_ff;

   // Combinational helpers.
   logic signed [PB:0] dx, dy;
   logic [PB-1:0] gxp, gyp, axc, ayc;
   logic [19:0] sx, sy;
   logic [15:0] fd;
   logic [63:0] tq, fdshift;
   logic signed [PB+2:0] e2;
   logic stepx, stepy;
   // The mm-per-step values stay below 2^29, and so does their root.
   logic [57:0] sqx, sqy;
   logic [54:0] ivnum;

   always_comb begin
      gxp = PB'($signed(gx_ff));
      gyp = PB'($signed(gy_ff));
      dx = $signed({gxp[PB-1], gxp}) - $signed({pos_x_ff[PB-1], pos_x_ff});
      dy = $signed({gyp[PB-1], gyp}) - $signed({pos_y_ff[PB-1], pos_y_ff});
      axc = dx[PB] ? PB'(-dx) : dx[PB-1:0];
      ayc = dy[PB] ? PB'(-dy) : dy[PB-1:0];
      sx = (xspm_ff == '0) ? 20'd1 : xspm_ff;
      sy = (yspm_ff == '0) ? 20'd1 : yspm_ff;
      fd = (feed_ff != '0) ? feed_ff : ((dfeed_ff == '0) ? 16'd1 : dfeed_ff);
      tq = 64'(tot_ff) * 64'(q_ff[31:0]);
      fdshift = {28'd0, fd, 20'd0};
      e2 = $signed({err_ff, 1'b0});
      stepx = e2 > -$signed({3'b000, span_y_ff});
      stepy = e2 < $signed({3'b000, span_x_ff});
      sqx = mx_ff[28:0] * mx_ff[28:0];
      sqy = ar.result[28:0] * ar.result[28:0];
      ivnum = q_ff[28:0] * tals_pkg::US_PER_MIN[25:0];
   end

   always_comb begin
      st_in = st_ff;
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff; span_x_in = span_x_ff; span_y_in = span_y_ff;
      steps_in = steps_ff; err_in = err_ff; intv_in = intv_ff; cd_in = cd_ff;
      dirs_in = dirs_ff; hold_in = hold_ff; pause_in = pause_ff; busy_in = busy_ff;
      ax_in = ax_ff; ay_in = ay_ff; tot_in = tot_ff; mdir_in = mdir_ff;
      mx_in = mx_ff; my_in = my_ff; q_in = q_ff; acc_in = acc_ff;
      ov_in = ov_ff; osx_in = osx_ff; osy_in = osy_ff; ost_in = ost_ff;
      cmd = '0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: if (req_valid && req_ready) st_in = S_EXEC;
         S_EXEC: begin
            osx_in = 1'b0; osy_in = 1'b0; ost_in = tals_pkg::ST_NONE; st_in = S_OUT;
            case (act_ff)
               tals_pkg::ACT_TICK: if (busy_ff) begin
                  cd_in = cd_ff - 32'd1;
                  ost_in = tals_pkg::ST_STEPPING;
                  if (cd_ff == 32'd1) begin
                     if (stepx) begin
                        err_in = err_ff - $signed({2'b00, span_y_ff});
                        if (lx_ff) begin
                           busy_in = 1'b0; steps_in = '0; cd_in = '0;
                           ost_in = tals_pkg::ST_LIMIT;
                        end else begin
                           pos_x_in = dirs_ff[0] ? pos_x_ff + 1'b1 : pos_x_ff - 1'b1;
                           osx_in = 1'b1;
                        end
                     end
                     if (stepy && !(stepx && lx_ff)) begin
                        err_in = err_in + $signed({2'b00, span_x_ff});
                        if (ly_ff) begin
                           busy_in = 1'b0; steps_in = '0; cd_in = '0;
                           ost_in = tals_pkg::ST_LIMIT;
                        end else begin
                           pos_y_in = dirs_ff[1] ? pos_y_ff + 1'b1 : pos_y_ff - 1'b1;
                           osy_in = 1'b1;
                        end
                     end
                     if (ost_in != tals_pkg::ST_LIMIT) begin
                        steps_in = steps_ff - 1'b1;
                        if (steps_ff == {{(PB-1){1'b0}}, 1'b1}) begin
                           busy_in = 1'b0; cd_in = '0; ost_in = tals_pkg::ST_DONE;
                        end else cd_in = intv_ff;
                     end
                  end
               end
               tals_pkg::ACT_MOVE: begin
                  if (busy_ff) ost_in = tals_pkg::ST_NONE;
                  else if (hold_ff || pause_ff) ost_in = tals_pkg::ST_REFUSED;
                  else if (dx != '0 && lx_ff) ost_in = tals_pkg::ST_X_LIMIT;
                  else if (dy != '0 && ly_ff) ost_in = tals_pkg::ST_Y_LIMIT;
                  else if (axc == '0 && ayc == '0) ost_in = tals_pkg::ST_NO_MOVE;
                  else begin
                     ax_in = axc; ay_in = ayc;
                     tot_in = (axc > ayc) ? axc : ayc;
                     mdir_in = {!dy[PB] && dy != '0, !dx[PB] && dx != '0};
                     st_in = S_RX;
                     // ratio: (ax << 20) / total
                     cmd.start = 1'b1;
                     cmd.num = 64'(axc) << tals_pkg::FRAC;
                     cmd.den = 64'((axc > ayc) ? axc : ayc);
                  end
               end
               tals_pkg::ACT_HOLD, tals_pkg::ACT_PAUSE: begin
                  if (act_ff == tals_pkg::ACT_HOLD) hold_in = 1'b1; else pause_in = 1'b1;
                  if (busy_ff) begin
                     busy_in = 1'b0; steps_in = '0; cd_in = '0;
                     ost_in = tals_pkg::ST_INTERRUPT;
                  end
               end
               tals_pkg::ACT_START: begin
                  if (hold_ff || pause_ff) begin hold_in = 1'b0; pause_in = 1'b0; end
                  else ost_in = tals_pkg::ST_NO_RESUME;
               end
               tals_pkg::ACT_RESET: begin
                  if (busy_ff) ost_in = tals_pkg::ST_INTERRUPT;
                  hold_in = 1'b0; pause_in = 1'b0; busy_in = 1'b0; steps_in = '0; cd_in = '0;
                  pos_x_in = '0; pos_y_in = '0; span_x_in = '0; span_y_in = '0;
                  err_in = '0; intv_in = '0; dirs_in = '0;
               end
               default: ;
            endcase
         end
         S_RX: if (ar.done) begin
            acc_in = ar.result; st_in = S_RY;
            cmd.start = 1'b1; cmd.num = 64'(ay_ff) << tals_pkg::FRAC; cmd.den = 64'(tot_ff);
         end
         S_RY: if (ar.done) begin
            my_in = ar.result; st_in = S_MX;
            cmd.start = 1'b1; cmd.num = acc_ff << 8; cmd.den = 64'(sx);
         end
         S_MX: if (ar.done) begin
            mx_in = ar.result; st_in = S_MY;
            cmd.start = 1'b1; cmd.num = my_ff << 8; cmd.den = 64'(sy);
         end
         S_MY: if (ar.done) begin
            my_in = ar.result; st_in = S_SQ;
            cmd.start = 1'b1; cmd.is_sqrt = 1'b1;
            cmd.num = 64'(sqx) + 64'(sqy);
         end
         S_SQ: if (ar.done) begin
            q_in = ar.result; st_in = S_FIN;
         end
         S_FIN: begin
            if (64'(tot_ff) < (64'd1 << 20) && tq < tals_pkg::NOMOVE_Q20) begin
               osx_in = 1'b0; osy_in = 1'b0; ost_in = tals_pkg::ST_NO_MOVE; st_in = S_OUT;
            end else begin
               st_in = S_IV;
               cmd.start = 1'b1;
               cmd.num = 64'(ivnum);
               cmd.den = fdshift;
            end
         end
         S_IV: if (ar.done) begin
            if (ar.result > 64'hFFFF_FFFF) intv_in = 32'hFFFF_FFFF;
            else if (ar.result < 64'(MIN_INTERVAL_US)) intv_in = 32'(MIN_INTERVAL_US);
            else intv_in = ar.result[31:0];
            span_x_in = ax_ff; span_y_in = ay_ff;
            err_in = $signed({2'b00, ax_ff}) - $signed({2'b00, ay_ff});
            steps_in = tot_ff; cd_in = 32'd1; dirs_in = mdir_ff; busy_in = 1'b1;
            osx_in = 1'b0; osy_in = 1'b0; ost_in = tals_pkg::ST_ACCEPTED; st_in = S_OUT;
         end
         S_OUT: begin ov_in = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
         xspm_ff <= tals_pkg::SPM_RESET; yspm_ff <= tals_pkg::SPM_RESET;
         dfeed_ff <= tals_pkg::FEED_RESET;
         pos_x_ff <= '0; pos_y_ff <= '0; span_x_ff <= '0; span_y_ff <= '0;
         steps_ff <= '0; err_ff <= '0; intv_ff <= '0; cd_ff <= '0; dirs_ff <= '0;
         hold_ff <= 1'b0; pause_ff <= 1'b0; busy_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
         if (csr_write) begin
            case (csr_index)
               tals_pkg::REG_X_SPM: xspm_ff <= csr_data;
               tals_pkg::REG_Y_SPM: yspm_ff <= csr_data;
               tals_pkg::REG_FEED:  dfeed_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         pos_x_ff <= pos_x_in; pos_y_ff <= pos_y_in;
         span_x_ff <= span_x_in; span_y_ff <= span_y_in;
         steps_ff <= steps_in; err_ff <= err_in; intv_ff <= intv_in; cd_ff <= cd_in;
         dirs_ff <= dirs_in; hold_ff <= hold_in; pause_ff <= pause_in; busy_ff <= busy_in;
      end
      if (req_valid && req_ready) begin
         act_ff <= req_action; gx_ff <= req_goal_x; gy_ff <= req_goal_y;
         feed_ff <= req_feed; lx_ff <= req_limit_x; ly_ff <= req_limit_y;
      end
      ax_ff <= ax_in; ay_ff <= ay_in; tot_ff <= tot_in; mdir_ff <= mdir_in;
      mx_ff <= mx_in; my_ff <= my_in; q_ff <= q_in; acc_ff <= acc_in;
      osx_ff <= osx_in; osy_ff <= osy_in; ost_ff <= ost_in;
   end

   assign rsp_valid  = ov_ff;
   assign rsp_step_x = osx_ff;
   assign rsp_step_y = osy_ff;
   assign rsp_dir_x  = dirs_ff[0];
   assign rsp_dir_y  = dirs_ff[1];
   assign rsp_at_x   = 32'($signed(pos_x_ff));
   assign rsp_at_y   = 32'($signed(pos_y_ff));
   assign rsp_moving = busy_ff;
   assign rsp_status = ost_ff;
endmodule

/* rtl/tals_checker.sv */
// Port-level checker for the step generator, bound to the top level.
// Depends on the top level's ports and the status codes of tals_pkg.
module tals_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_step_x,
   input logic       rsp_step_y,
   input logic       rsp_moving,
   input logic [3:0] rsp_status
);
   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");
   a_step_only_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_step_x || rsp_step_y) |->
      (rsp_status == tals_pkg::ST_STEPPING || rsp_status == tals_pkg::ST_DONE ||
       rsp_status == tals_pkg::ST_LIMIT))
      else $error("step pulse outside motion");
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tals_pkg::ST_DONE || rsp_status == tals_pkg::ST_INTERRUPT ||
                    rsp_status == tals_pkg::ST_LIMIT)
      |-> !rsp_moving) else $error("moving after stop");
endmodule

bind two_axis_line_step_generator tals_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_step_x(rsp_step_x),
   .rsp_step_y(rsp_step_y), .rsp_moving(rsp_moving), .rsp_status(rsp_status));

/* tb/tb_two_axis_line_step_generator.sv */
// Self-checking testbench for the two-axis line step generator.
// Holds its own motion predictor in a scoreboard class; depends on tals_pkg, tals_if and the RTL.
module tb_two_axis_line_step_generator;
   timeunit 1ns;
   timeprecision 1ps;

   // One request item and one response item, as carried on the channels.
   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic [15:0]        feed;
      logic               limit_x;
      logic               limit_y;
   } req_item_type;

   typedef struct packed {
      logic               step_x;
      logic               dir_x;
      logic               step_y;
      logic               dir_y;
      logic signed [31:0] at_x;
      logic signed [31:0] at_y;
      logic               moving;
      logic [3:0]         status;
   } rsp_item_type;

   localparam int          MIN_IV   = 1000;
   localparam logic [2:0]  ACT_BAD6 = 3'd6;
   localparam logic [2:0]  ACT_BAD7 = 3'd7;
   localparam int          HOLD_OFF_CYCLES = 3000;

   // The scoreboard mirrors the motion state and keeps the queue of predicted responses.
   class step_scoreboard;
      logic [19:0]        x_spm, y_spm;
      logic [15:0]        dflt_feed;
      logic signed [31:0] pos_x, pos_y;
      longint unsigned    span_x, span_y, steps_left;
      longint             line_err;
      logic [31:0]        interval_us, countdown_us;
      logic [1:0]         dirs;
      bit                 held, paused, busy;
      rsp_item_type       pending[$];
      int                 errors;

      function void clear_motion();
         pos_x = 0; pos_y = 0; span_x = 0; span_y = 0; steps_left = 0;
         line_err = 0; interval_us = 0; countdown_us = 0; dirs = 0;
         held = 0; paused = 0; busy = 0;
      endfunction

      function new();
         x_spm = tals_pkg::SPM_RESET; y_spm = tals_pkg::SPM_RESET;
         dflt_feed = tals_pkg::FEED_RESET;
         errors = 0;
         clear_motion();
      endfunction

      function void set_reg(logic [1:0] idx, logic [19:0] val);
         case (idx)
            tals_pkg::REG_X_SPM: x_spm = val;
            tals_pkg::REG_Y_SPM: y_spm = val;
            tals_pkg::REG_FEED:  dflt_feed = val[15:0];
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void halt();
         busy = 0; steps_left = 0; countdown_us = 0;
      endfunction

      // Move request: refusal checks, then interval from the mm length and feed.
      function logic [3:0] start_move(req_item_type r);
         longint dx, dy;
         longint unsigned ax, ay, total, mx, my, q, fd, sx, sy, iv;
         if (busy) return tals_pkg::ST_NONE;
         if (held || paused) return tals_pkg::ST_REFUSED;
         dx = longint'(r.goal_x) - longint'(pos_x);
         dy = longint'(r.goal_y) - longint'(pos_y);
         if (dx != 0 && r.limit_x) return tals_pkg::ST_X_LIMIT;
         if (dy != 0 && r.limit_y) return tals_pkg::ST_Y_LIMIT;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         total = ax > ay ? ax : ay;
         if (total == 0) return tals_pkg::ST_NO_MOVE;
         sx = x_spm == 0 ? 1 : x_spm;
         sy = y_spm == 0 ? 1 : y_spm;
         mx = (((ax << tals_pkg::FRAC) / total) << 8) / sx;
         my = (((ay << tals_pkg::FRAC) / total) << 8) / sy;
         q = int_sqrt(mx * mx + my * my);
         if (total < (64'd1 << 20) && total * q < tals_pkg::NOMOVE_Q20)
            return tals_pkg::ST_NO_MOVE;
         fd = r.feed;
         if (fd == 0) fd = dflt_feed == 0 ? 1 : dflt_feed;
         iv = (tals_pkg::US_PER_MIN * q) / (fd << tals_pkg::FRAC);
         if (iv > 64'hFFFF_FFFF) iv = 64'hFFFF_FFFF;
         if (iv < MIN_IV) iv = MIN_IV;
         span_x = ax; span_y = ay;
         line_err = longint'(ax) - longint'(ay);
         steps_left = total;
         interval_us = iv[31:0];
         countdown_us = 1;
         dirs = {dy > 0, dx > 0};
         busy = 1;
         return tals_pkg::ST_ACCEPTED;
      endfunction

      // One microsecond tick: count down, and one Bresenham step when the count reaches zero.
      function logic [3:0] run_tick(req_item_type r, output logic px, output logic py);
         longint e2;
         px = 0; py = 0;
         if (!busy) return tals_pkg::ST_NONE;
         countdown_us = countdown_us - 1;
         if (countdown_us != 0) return tals_pkg::ST_STEPPING;
         e2 = 2 * line_err;
         if (e2 > -longint'(span_y)) begin
            line_err = line_err - longint'(span_y);
            if (r.limit_x) begin halt(); return tals_pkg::ST_LIMIT; end
            pos_x = dirs[0] ? pos_x + 1 : pos_x - 1;
            px = 1;
         end
         if (e2 < longint'(span_x)) begin
            line_err = line_err + longint'(span_x);
            if (r.limit_y) begin halt(); return tals_pkg::ST_LIMIT; end
            pos_y = dirs[1] ? pos_y + 1 : pos_y - 1;
            py = 1;
         end
         steps_left = steps_left - 1;
         if (steps_left == 0) begin halt(); return tals_pkg::ST_DONE; end
         countdown_us = interval_us;
         return tals_pkg::ST_STEPPING;
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         logic px, py;
         logic [3:0] st;
         px = 0; py = 0; st = tals_pkg::ST_NONE;
         case (r.action)
            tals_pkg::ACT_TICK:  st = run_tick(r, px, py);
            tals_pkg::ACT_MOVE:  st = start_move(r);
            tals_pkg::ACT_HOLD, tals_pkg::ACT_PAUSE: begin
               if (r.action == tals_pkg::ACT_HOLD) held = 1; else paused = 1;
               if (busy) begin halt(); st = tals_pkg::ST_INTERRUPT; end
            end
            tals_pkg::ACT_START: begin
               if (held || paused) begin held = 0; paused = 0; end
               else st = tals_pkg::ST_NO_RESUME;
            end
            tals_pkg::ACT_RESET: begin
               if (busy) st = tals_pkg::ST_INTERRUPT;
               clear_motion();
            end
            default: ;
         endcase
         e.step_x = px; e.dir_x = dirs[0];
         e.step_y = py; e.dir_y = dirs[1];
         e.at_x = pos_x; e.at_y = pos_y;
         e.moving = busy; e.status = st;
         pending.push_back(e);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.step_x !== e.step_x) report("step_x", e.step_x, got.step_x);
         if (got.dir_x !== e.dir_x) report("dir_x", e.dir_x, got.dir_x);
         if (got.step_y !== e.step_y) report("step_y", e.step_y, got.step_y);
         if (got.dir_y !== e.dir_y) report("dir_y", e.dir_y, got.dir_y);
         if (got.at_x !== e.at_x) report("at_x", e.at_x, got.at_x);
         if (got.at_y !== e.at_y) report("at_y", e.at_y, got.at_y);
         if (got.moving !== e.moving) report("moving", e.moving, got.moving);
         if (got.status !== e.status) report("status", e.status, got.status);
      endfunction

      function void report(string field, longint want, longint seen);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, seen);
         errors++;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [19:0] csr_data;

   tals_if #(.payload_type(req_item_type)) req_ch (.clock(clock));
   tals_if #(.payload_type(rsp_item_type)) rsp_ch (.clock(clock));

   two_axis_line_step_generator uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_action(req_ch.data.action), .req_goal_x(req_ch.data.goal_x),
      .req_goal_y(req_ch.data.goal_y), .req_feed(req_ch.data.feed),
      .req_limit_x(req_ch.data.limit_x), .req_limit_y(req_ch.data.limit_y),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_step_x(rsp_ch.data.step_x), .rsp_dir_x(rsp_ch.data.dir_x),
      .rsp_step_y(rsp_ch.data.step_y), .rsp_dir_y(rsp_ch.data.dir_y),
      .rsp_at_x(rsp_ch.data.at_x), .rsp_at_y(rsp_ch.data.at_y),
      .rsp_moving(rsp_ch.data.moving), .rsp_status(rsp_ch.data.status)
   );

   step_scoreboard motion_sb = new();
   int  burst_left = 0;
   bit  hold_off_request = 0;
   bit  stimulus_done = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #150ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Offers one request item. Bursts of random length are separated by random gaps,
   // and valid stays high across consecutive items of a burst.
   task automatic send_item(req_item_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      motion_sb.note_request(r);
   endtask

   function automatic req_item_type make_item(logic [2:0] act, logic signed [31:0] gx,
                                              logic signed [31:0] gy, logic [15:0] fd,
                                              logic lx, logic ly);
      req_item_type r;
      r.action = act; r.goal_x = gx; r.goal_y = gy; r.feed = fd;
      r.limit_x = lx; r.limit_y = ly;
      return r;
   endfunction

   // A tick carries random goal and feed noise so that those fields toggle too.
   task automatic send_ticks(int n, int limit_odds);
      for (int i = 0; i < n; i++)
         send_item(make_item(tals_pkg::ACT_TICK, $urandom, $urandom, $urandom,
                             $urandom_range(0, limit_odds) == 0,
                             $urandom_range(0, limit_odds) == 0));
   endtask

   // Registers change only once every response is back and the block is quiet.
   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (motion_sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      motion_sb.set_reg(idx, val);
   endtask

   task automatic set_regs(logic [19:0] xs, logic [19:0] ys, logic [15:0] fd);
      write_reg(tals_pkg::REG_X_SPM, xs);
      write_reg(tals_pkg::REG_Y_SPM, ys);
      write_reg(tals_pkg::REG_FEED, {4'd0, fd});
   endtask

   // A well-formed move: a short offset from the current position, then a few ticks.
   // Sometimes the goal is a random full-width value, which gives a long move.
   task automatic random_scenario();
      logic signed [31:0] gx, gy;
      int pick, ticks;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         gx = $urandom; gy = $urandom;
      end else begin
         gx = motion_sb.pos_x + $signed($urandom_range(0, 6)) - 3;
         gy = motion_sb.pos_y + $signed($urandom_range(0, 6)) - 3;
      end
      send_item(make_item(tals_pkg::ACT_MOVE, gx, gy,
                          ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                          $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0));
      ticks = $urandom_range(1, 5);
      send_ticks(ticks, 200);
      // Noise: events, unknown actions and stray moves.
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 6))
            0: send_item(make_item(tals_pkg::ACT_HOLD, $urandom, $urandom, $urandom, 0, 0));
            1: send_item(make_item(tals_pkg::ACT_PAUSE, $urandom, $urandom, $urandom, 0, 0));
            2: send_item(make_item(tals_pkg::ACT_START, $urandom, $urandom, $urandom, 0, 0));
            3: send_item(make_item(tals_pkg::ACT_RESET, $urandom, $urandom, $urandom, 0, 0));
            4: send_item(make_item(ACT_BAD6, $urandom, $urandom, $urandom, 1, 1));
            5: send_item(make_item(ACT_BAD7, $urandom, $urandom, $urandom, 1, 0));
            default: send_item(make_item(tals_pkg::ACT_MOVE, $urandom, $urandom, $urandom,
                                         $urandom_range(0, 1), $urandom_range(0, 1)));
         endcase
      end
      if (motion_sb.held || motion_sb.paused)
         send_item(make_item(tals_pkg::ACT_START, 0, 0, 0, 0, 0));
   endtask

   initial begin
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_index    = tals_pkg::REG_X_SPM;
      csr_data     = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the register defaults.
      send_item(make_item(tals_pkg::ACT_TICK, 0, 0, 0, 0, 0));    // idle tick
      send_item(make_item(tals_pkg::ACT_MOVE, 0, 0, 0, 0, 0));    // zero length
      send_item(make_item(tals_pkg::ACT_MOVE, 2, 1, 0, 1, 0));    // X limit pressed
      send_item(make_item(tals_pkg::ACT_MOVE, 0, 2, 0, 0, 1));    // Y limit pressed
      send_item(make_item(tals_pkg::ACT_MOVE, 1, 1, 0, 0, 0));    // accepted
      send_item(make_item(tals_pkg::ACT_MOVE, 9, 9, 0, 0, 0));    // ignored while moving
      send_item(make_item(tals_pkg::ACT_TICK, 0, 0, 0, 0, 0));    // single step, done
      send_item(make_item(tals_pkg::ACT_MOVE, -2, 3, 16'hFFFF, 0, 0));
      send_ticks(1001, 1000000);                                  // first step, then a second
      send_item(make_item(tals_pkg::ACT_HOLD, 0, 0, 0, 0, 0));    // interrupts the move
      send_item(make_item(tals_pkg::ACT_MOVE, 5, 5, 0, 0, 0));    // refused while held
      send_item(make_item(tals_pkg::ACT_START, 0, 0, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_START, 0, 0, 0, 0, 0));   // nothing to resume
      send_item(make_item(tals_pkg::ACT_PAUSE, 0, 0, 0, 0, 0));   // pause while idle
      send_item(make_item(tals_pkg::ACT_START, 0, 0, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_MOVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, 0));
      send_item(make_item(tals_pkg::ACT_TICK, 0, 0, 0, 1, 0));    // limit stop on X
      send_item(make_item(tals_pkg::ACT_MOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_TICK, 0, 0, 0, 0, 1));    // limit stop on Y
      send_item(make_item(tals_pkg::ACT_MOVE, 7, -7, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_RESET, 0, 0, 0, 0, 0));   // reset event mid-move
      send_item(make_item(ACT_BAD6, 1, 1, 1, 1, 1));
      send_item(make_item(ACT_BAD7, 1, 1, 1, 1, 1));

      // Zero registers act as one; the largest steps-per-mm makes short moves vanish.
      set_regs(20'd0, 20'd0, 16'd0);
      send_item(make_item(tals_pkg::ACT_MOVE, 3, 1, 0, 0, 0));
      send_ticks(3, 1000000);
      send_item(make_item(tals_pkg::ACT_RESET, 0, 0, 0, 0, 0));
      set_regs(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_item(make_item(tals_pkg::ACT_MOVE, 2, 1, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_MOVE, 5000, 0, 0, 0, 0));
      send_item(make_item(tals_pkg::ACT_RESET, 0, 0, 0, 0, 0));

      // Random part across several register settings.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_regs(tals_pkg::SPM_RESET, tals_pkg::SPM_RESET, tals_pkg::FEED_RESET);
            1: set_regs(20'd1, 20'hFFFFF, 16'd1);
            2: set_regs($urandom, $urandom, $urandom);
            3: set_regs(20'hFFFFF, 20'd1, 16'hFFFF);
            default: set_regs($urandom_range(1, 40000), $urandom_range(1, 40000),
                              $urandom_range(1, 5000));
         endcase
         for (int s = 0; s < 40; s++) begin
            if (phase == 1 && s == 20) hold_off_request = 1;
            random_scenario();
         end
      end
      req_ch.valid <= 1'b0;
      stimulus_done = 1;
   end

   // Receiver: stall pattern chosen per window, plus one long hold-off.
   initial begin
      int window;
      int odds;
      window = 0;
      odds = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            motion_sb.check_response(rsp_ch.data);
         if (hold_off_request) begin
            hold_off_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (window == 0) begin
            window = $urandom_range(50, 300);
            odds = $urandom_range(0, 3);
         end
         window--;
         rsp_ch.ready <= (odds == 0) ? 1'b1 : ($urandom_range(0, odds) == 0);
      end
   end

   // End of run: drain, allow the block's latency, then report.
   initial begin
      wait (stimulus_done);
      while (motion_sb.pending.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (motion_sb.errors == 0 && motion_sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

/* two_axis_line_step_generator.f */
rtl/tals_pkg.sv
rtl/tals_if.sv
rtl/tals_alu.sv
rtl/two_axis_line_step_generator.sv
rtl/tals_checker.sv
tb/tb_two_axis_line_step_generator.sv
